@@ rtl/core/csfr_pkg.sv @@
// Shared constants and result type for the sensor frame receiver.
`timescale 1ns / 1ps

package csfr_pkg;

    localparam int unsigned FRAME_LEN_DEF = 9;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned PAYLOAD_W     = 56;
    localparam int unsigned POS_W         = 4;

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hFF;

    typedef struct packed {
        logic                 frame_ok;
        logic                 frame_bad;
        logic [PAYLOAD_W-1:0] payload;
        logic [POS_W-1:0]     position;
    } t_result;

endpackage

@@ rtl/core/csfr_frame_track.sv @@
// Header hunt, byte count, running checksum and payload shift register.
`timescale 1ns / 1ps

module csfr_frame_track
    import csfr_pkg::*;
#(
    parameter int unsigned FRAME_LEN = FRAME_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output t_result           o_result
);

    localparam logic [POS_W-1:0] LastPos = POS_W'(FRAME_LEN - 1);

    logic [POS_W-1:0]     r_pos,   n_pos;
    logic [BYTE_W-1:0]    r_sum,   n_sum;
    logic [PAYLOAD_W-1:0] r_shift, n_shift;
    logic [BYTE_W-1:0]    expect_sum;

    assign expect_sum = BYTE_W'(~r_sum + 1'b1);

    always_comb begin
        n_pos              = r_pos;
        n_sum              = r_sum;
        n_shift            = r_shift;
        o_result.frame_ok  = 1'b0;
        o_result.frame_bad = 1'b0;
        o_result.payload   = '0;
        if (r_pos == '0) begin
            if (i_rx_byte == HEADER_BYTE) begin
                n_pos   = POS_W'(1);
                n_sum   = '0;
                n_shift = '0;
            end
        end else if (r_pos < LastPos) begin
            n_sum   = r_sum + i_rx_byte;
            n_shift = {r_shift[PAYLOAD_W-BYTE_W-1:0], i_rx_byte};
            n_pos   = r_pos + POS_W'(1);
        end else begin
            // checksum byte, also taken when the count is out of range
            o_result.frame_ok  = (i_rx_byte == expect_sum);
            o_result.frame_bad = (i_rx_byte != expect_sum);
            o_result.payload   = r_shift;
            n_pos              = '0;
        end
        o_result.position = n_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_sum   <= '0;
            r_shift <= '0;
        end else if (i_take) begin
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_shift <= n_shift;
        end
    end

endmodule

@@ rtl/core/csfr_out_buf.sv @@
// Result register with a skid entry so one more input is taken while output is stalled.
`timescale 1ns / 1ps

module csfr_out_buf
    import csfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop      = r_out_valid && !i_stall;
    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid <= i_result;
            end else begin
                r_out <= i_result;
            end
        end
    end

endmodule

@@ rtl/core/checksummed_sensor_frame_receiver_unit.sv @@
// Each byte transfer's result is registered in the result register, or in the skid entry while the output is stalled.
// Throughput: one byte per cycle while o_stall is low.
// A skid entry behind the result register keeps input flowing for one stalled
// result; input stalls only while both entries are held.
// Reset (synchronous, active low) returns to header hunt with an empty output.
`timescale 1ns / 1ps

module checksummed_sensor_frame_receiver_unit
    import csfr_pkg::*;
#(
    parameter int unsigned FRAME_LEN = FRAME_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_frame_ok,
    output logic                 o_frame_bad,
    output logic [PAYLOAD_W-1:0] o_payload,
    output logic [POS_W-1:0]     o_position
);

    logic    take;
    logic    full;
    t_result res;
    t_result out_res;

    assign o_stall = full;
    assign take    = i_valid && !full;

    csfr_frame_track #(
        .FRAME_LEN(FRAME_LEN)
    ) u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_rx_byte (i_rx_byte),
        .o_result  (res)
    );

    csfr_out_buf u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (take),
        .i_result (res),
        .i_stall  (i_stall),
        .o_full   (full),
        .o_valid  (o_valid),
        .o_result (out_res)
    );

    assign o_frame_ok  = out_res.frame_ok;
    assign o_frame_bad = out_res.frame_bad;
    assign o_payload   = out_res.payload;
    assign o_position  = out_res.position;

endmodule
